// ===== src/lew_pkg.sv =====
// Shared types, key codes and character class functions for the line editor.
`timescale 1ns / 1ps

package lew_pkg;

    localparam int LEN_W = 6;

    typedef logic [LEN_W-1:0] len_t;

    localparam logic [7:0] KEY_DEL    = 8'd127;
    localparam logic [7:0] KEY_KILL   = 8'h18;
    localparam logic [7:0] KEY_EOF    = 8'h04;
    localparam logic [7:0] KEY_WERASE = 8'h17;
    localparam logic [7:0] KEY_LF     = 8'h0A;
    localparam logic [7:0] BELL_BYTE  = 8'h07;

    localparam len_t WIDTH_RESET = 6'd40;
    localparam len_t WIDTH_MIN   = 6'd2;
    localparam int   WIDTH_MAX   = 62;

    localparam logic [1:0] ACT_ECHO  = 2'd0;
    localparam logic [1:0] ACT_ERASE = 2'd1;
    localparam logic [1:0] ACT_BELL  = 2'd2;
    localparam logic [1:0] ACT_END   = 2'd3;

    localparam logic [2:0] LEN_HOLD  = 3'd0;
    localparam logic [2:0] LEN_DEC   = 3'd1;
    localparam logic [2:0] LEN_CLEAR = 3'd2;
    localparam logic [2:0] LEN_TO_P  = 3'd3;
    localparam logic [2:0] LEN_TO_W  = 3'd4;
    localparam logic [2:0] LEN_ECHO  = 3'd5;

    localparam logic [2:0] EM_DEL   = 3'd0;
    localparam logic [2:0] EM_KILL  = 3'd1;
    localparam logic [2:0] EM_DIFF  = 3'd2;
    localparam logic [2:0] EM_NL    = 3'd3;
    localparam logic [2:0] EM_COPY  = 3'd4;
    localparam logic [2:0] EM_ECHO  = 3'd5;
    localparam logic [2:0] EM_BELL  = 3'd6;
    localparam logic [2:0] EM_END   = 3'd7;

    typedef struct packed {
        logic       load_byte;
        logic       p_load;
        logic       p_dec;
        logic       rd_en;
        logic       rd_copy;
        logic       j_clear;
        logic       j_inc;
        logic       mem_wr;
        logic       wr_copy;
        logic [2:0] len_op;
        logic       emit;
        logic [2:0] emit_sel;
        logic       emit_last;
    } lew_cmd_t;

    typedef struct packed {
        logic is_del;
        logic is_kill;
        logic is_eof;
        logic is_werase;
        logic is_print;
        logic wrap_needed;
        logic len_zero;
        logic p_zero;
        logic diff_zero;
        logic w_zero;
        logic rd_space;
        logic rd_alnum;
        logic copy_last;
        logic out_free;
    } lew_sts_t;

    function automatic logic is_space(input logic [7:0] c);
        return c inside {8'h20, [8'h09:8'h0D]};
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

endpackage

// ===== src/lew_ctrl.sv =====
// Sequencer for the line editor: decodes a key and steps scans, copies and results.
`timescale 1ns / 1ps

module lew_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lew_pkg::lew_sts_t  sts,
    output lew_pkg::lew_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_DEL      = 4'd2;
    localparam logic [3:0] S_KILL     = 4'd3;
    localparam logic [3:0] S_EOF      = 4'd4;
    localparam logic [3:0] S_BELL     = 4'd5;
    localparam logic [3:0] S_SP_RD    = 4'd6;
    localparam logic [3:0] S_SP_CHK   = 4'd7;
    localparam logic [3:0] S_AN_RD    = 4'd8;
    localparam logic [3:0] S_AN_CHK   = 4'd9;
    localparam logic [3:0] S_WE_EMIT  = 4'd10;
    localparam logic [3:0] S_WR_ERASE = 4'd11;
    localparam logic [3:0] S_WR_NL    = 4'd12;
    localparam logic [3:0] S_CP_RD    = 4'd13;
    localparam logic [3:0] S_CP_EMIT  = 4'd14;
    localparam logic [3:0] S_ECHO     = 4'd15;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       wrap_mode_reg;
    logic       wrap_mode_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd            = '0;
        cmd.len_op     = lew_pkg::LEN_HOLD;
        cmd.emit_sel   = lew_pkg::EM_ECHO;
        state_next     = state_reg;
        wrap_mode_next = wrap_mode_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_byte = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.is_del)
                begin
                    state_next = S_DEL;
                end
                else if (sts.is_kill)
                begin
                    state_next = S_KILL;
                end
                else if (sts.is_eof)
                begin
                    state_next = S_EOF;
                end
                else if (sts.is_werase)
                begin
                    cmd.p_load     = 1'b1;
                    wrap_mode_next = 1'b0;
                    state_next     = S_SP_RD;
                end
                else if (sts.is_print)
                begin
                    if (sts.wrap_needed)
                    begin
                        cmd.p_load     = 1'b1;
                        wrap_mode_next = 1'b1;
                        state_next     = S_AN_RD;
                    end
                    else
                    begin
                        state_next = S_ECHO;
                    end
                end
                else
                begin
                    state_next = S_BELL;
                end
            end
            S_DEL:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = lew_pkg::EM_DEL;
                    cmd.emit_last = 1'b1;
                    cmd.len_op    = lew_pkg::LEN_DEC;
                    state_next    = S_IDLE;
                end
            end
            S_KILL:
            begin
                if (sts.len_zero)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = lew_pkg::EM_KILL;
                    cmd.emit_last = 1'b1;
                    cmd.len_op    = lew_pkg::LEN_CLEAR;
                    state_next    = S_IDLE;
                end
            end
            S_EOF:
            begin
                if (!sts.len_zero)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = lew_pkg::EM_END;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_BELL:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = lew_pkg::EM_BELL;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_SP_RD:
            begin
                if (sts.p_zero)
                begin
                    state_next = S_WE_EMIT;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_SP_CHK;
                end
            end
            S_SP_CHK:
            begin
                if (sts.rd_space)
                begin
                    cmd.p_dec  = 1'b1;
                    state_next = S_SP_RD;
                end
                else
                begin
                    state_next = S_AN_CHK;
                end
            end
            S_AN_RD:
            begin
                if (sts.p_zero)
                begin
                    state_next = wrap_mode_reg ? S_WR_ERASE : S_WE_EMIT;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_AN_CHK;
                end
            end
            S_AN_CHK:
            begin
                if (sts.rd_alnum)
                begin
                    cmd.p_dec  = 1'b1;
                    state_next = S_AN_RD;
                end
                else
                begin
                    state_next = wrap_mode_reg ? S_WR_ERASE : S_WE_EMIT;
                end
            end
            S_WE_EMIT:
            begin
                if (sts.diff_zero)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = lew_pkg::EM_DIFF;
                    cmd.emit_last = 1'b1;
                    cmd.len_op    = lew_pkg::LEN_TO_P;
                    state_next    = S_IDLE;
                end
            end
            S_WR_ERASE:
            begin
                if (sts.w_zero)
                begin
                    state_next = S_WR_NL;
                end
                else if (sts.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = lew_pkg::EM_DIFF;
                    state_next   = S_WR_NL;
                end
            end
            S_WR_NL:
            begin
                if (sts.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = lew_pkg::EM_NL;
                    cmd.j_clear  = 1'b1;
                    if (sts.w_zero)
                    begin
                        cmd.len_op = lew_pkg::LEN_CLEAR;
                        state_next = S_ECHO;
                    end
                    else
                    begin
                        state_next = S_CP_RD;
                    end
                end
            end
            S_CP_RD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_copy = 1'b1;
                state_next  = S_CP_EMIT;
            end
            S_CP_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = lew_pkg::EM_COPY;
                    cmd.mem_wr   = 1'b1;
                    cmd.wr_copy  = 1'b1;
                    cmd.j_inc    = 1'b1;
                    if (sts.copy_last)
                    begin
                        cmd.len_op = lew_pkg::LEN_TO_W;
                        state_next = S_ECHO;
                    end
                    else
                    begin
                        state_next = S_CP_RD;
                    end
                end
            end
            S_ECHO:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = lew_pkg::EM_ECHO;
                    cmd.emit_last = 1'b1;
                    cmd.mem_wr    = 1'b1;
                    cmd.len_op    = lew_pkg::LEN_ECHO;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wrap_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wrap_mode_reg <= wrap_mode_next;
        end
    end

endmodule

// ===== src/lew_datapath.sv =====
// Line store, pointers, width register and result register of the line editor.
`timescale 1ns / 1ps

module lew_datapath
#(
    parameter int LINE_CAPACITY = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         key_byte,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [5:0]         cfg_data,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [15:0]        m_tdata,
    output logic [1:0]         m_tuser,
    output logic               m_tlast,
    input  lew_pkg::lew_cmd_t  cmd,
    output lew_pkg::lew_sts_t  sts
);

    localparam int AW        = $clog2(LINE_CAPACITY);
    localparam int CAP_LIMIT = (LINE_CAPACITY - 1 < lew_pkg::WIDTH_MAX)
                             ? LINE_CAPACITY - 1 : lew_pkg::WIDTH_MAX;
    localparam lew_pkg::len_t LIMIT_MAX = lew_pkg::len_t'(CAP_LIMIT);

    typedef logic [AW-1:0] addr_t;

    logic [7:0]    line_store_reg [LINE_CAPACITY];
    logic [7:0]    rd_data_reg;
    logic [7:0]    byte_reg;
    lew_pkg::len_t len_reg;
    lew_pkg::len_t len_next;
    lew_pkg::len_t p_reg;
    lew_pkg::len_t j_reg;
    lew_pkg::len_t width_reg;
    lew_pkg::len_t limit;
    lew_pkg::len_t diff;
    lew_pkg::len_t rd_ptr;
    lew_pkg::len_t wr_ptr;
    logic          out_valid_reg;
    logic [1:0]    act_reg;
    logic [7:0]    echo_reg;
    lew_pkg::len_t count_reg;
    logic          last_reg;
    logic [1:0]    act_next;
    logic [7:0]    echo_next;
    lew_pkg::len_t count_next;

    assign cfg_ready = 1'b1;
    assign diff      = len_reg - p_reg;
    assign rd_ptr    = cmd.rd_copy ? (p_reg + j_reg) : (p_reg - 6'd1);
    assign wr_ptr    = cmd.wr_copy ? j_reg : len_reg;

    always_comb
    begin
        if (width_reg < lew_pkg::WIDTH_MIN)
        begin
            limit = lew_pkg::WIDTH_MIN;
        end
        else if (width_reg > LIMIT_MAX)
        begin
            limit = LIMIT_MAX;
        end
        else
        begin
            limit = width_reg;
        end
    end

    always_comb
    begin
        sts.is_del      = (byte_reg == lew_pkg::KEY_DEL);
        sts.is_kill     = (byte_reg == lew_pkg::KEY_KILL);
        sts.is_eof      = (byte_reg == lew_pkg::KEY_EOF);
        sts.is_werase   = (byte_reg == lew_pkg::KEY_WERASE);
        sts.is_print    = lew_pkg::is_alnum(byte_reg) || lew_pkg::is_space(byte_reg);
        sts.wrap_needed = (len_reg >= limit);
        sts.len_zero    = (len_reg == '0);
        sts.p_zero      = (p_reg == '0);
        sts.diff_zero   = (diff == '0);
        sts.w_zero      = (p_reg == '0) || (diff == '0);
        sts.rd_space    = lew_pkg::is_space(rd_data_reg);
        sts.rd_alnum    = lew_pkg::is_alnum(rd_data_reg);
        sts.copy_last   = ((j_reg + 6'd1) == diff);
        sts.out_free    = !out_valid_reg || m_tready;
    end

    always_comb
    begin
        case (cmd.len_op)
            lew_pkg::LEN_HOLD:  len_next = len_reg;
            lew_pkg::LEN_DEC:   len_next = sts.len_zero ? len_reg : len_reg - 6'd1;
            lew_pkg::LEN_CLEAR: len_next = '0;
            lew_pkg::LEN_TO_P:  len_next = p_reg;
            lew_pkg::LEN_TO_W:  len_next = diff;
            lew_pkg::LEN_ECHO:
                len_next = (byte_reg == lew_pkg::KEY_LF) ? '0 : len_reg + 6'd1;
            default:            len_next = len_reg;
        endcase
    end

    always_comb
    begin
        act_next   = lew_pkg::ACT_ECHO;
        echo_next  = '0;
        count_next = '0;
        case (cmd.emit_sel)
            lew_pkg::EM_DEL:
            begin
                act_next   = lew_pkg::ACT_ERASE;
                count_next = 6'd1;
            end
            lew_pkg::EM_KILL:
            begin
                act_next   = lew_pkg::ACT_ERASE;
                count_next = len_reg;
            end
            lew_pkg::EM_DIFF:
            begin
                act_next   = lew_pkg::ACT_ERASE;
                count_next = diff;
            end
            lew_pkg::EM_NL:   echo_next = lew_pkg::KEY_LF;
            lew_pkg::EM_COPY: echo_next = rd_data_reg;
            lew_pkg::EM_ECHO: echo_next = byte_reg;
            lew_pkg::EM_BELL:
            begin
                act_next  = lew_pkg::ACT_BELL;
                echo_next = lew_pkg::BELL_BYTE;
            end
            lew_pkg::EM_END:  act_next = lew_pkg::ACT_END;
            default:          act_next = lew_pkg::ACT_ECHO;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
        begin
            line_store_reg[addr_t'(wr_ptr)] <= cmd.wr_copy ? rd_data_reg : byte_reg;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= line_store_reg[addr_t'(rd_ptr)];
        end
        if (cmd.load_byte)
        begin
            byte_reg <= key_byte;
        end
        if (cmd.p_load)
        begin
            p_reg <= len_reg;
        end
        else if (cmd.p_dec)
        begin
            p_reg <= p_reg - 6'd1;
        end
        if (cmd.j_clear)
        begin
            j_reg <= '0;
        end
        else if (cmd.j_inc)
        begin
            j_reg <= j_reg + 6'd1;
        end
        if (cmd.emit)
        begin
            act_reg   <= act_next;
            echo_reg  <= echo_next;
            count_reg <= count_next;
            last_reg  <= cmd.emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            width_reg     <= lew_pkg::WIDTH_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg <= len_next;
            if (cfg_valid && cfg_ready)
            begin
                width_reg <= cfg_data;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, count_reg, echo_reg};
    assign m_tuser  = act_reg;
    assign m_tlast  = last_reg;

    assert property (@(posedge clk) disable iff (!rst_n) len_reg <= LIMIT_MAX)
        else $error("line length exceeds the wrap limit");

    assert property (@(posedge clk) disable iff (!rst_n) cmd.emit |-> sts.out_free)
        else $error("result written while the output register is occupied");

    assert property (@(posedge clk) disable iff (!rst_n) cmd.rd_en |-> rd_ptr < len_reg)
        else $error("line store read beyond the current line");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mem_wr && cmd.wr_copy) |-> (j_reg < p_reg + j_reg))
        else $error("wrap copy overwrites a byte that is not yet moved");

endmodule

// ===== src/line_editor_word_wrap.sv =====
// Top level of the line editor with word wrap.
// A key is accepted in the idle state and decoded in the next cycle; for keys without a scan
// a result state then registers the result once the output register is free.
// A word erase reads bytes back from the store, and a wrap reads bytes and moves the word,
// with output stalls on top; a new key is taken only once the last one is finished.
// Reset clears the line length and loads a wrap width of 40; the store is not cleared.
`timescale 1ns / 1ps

module line_editor_word_wrap
#(
    parameter int LINE_CAPACITY = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] key_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] echo_byte, [13:8] erase_count, [15:14] zero
    output logic [1:0]  m_tuser,   // [1:0] action
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data   // [5:0] line_width
);

    lew_pkg::lew_cmd_t cmd;
    lew_pkg::lew_sts_t sts;

    lew_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lew_datapath
    #(
        .LINE_CAPACITY (LINE_CAPACITY)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_byte  (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the line editor with word wrap.
`timescale 1ns / 1ps

module testbench;

    typedef struct {
        logic [1:0] action;
        logic [7:0] echo_byte;
        logic [5:0] erase_count;
        logic       last;
    } display_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [5:0]  cfg_data = 6'd0;

    logic [7:0]  keys_to_type[$];
    display_t    expected_display[$];
    int          keys_typed = 0;
    int          keys_taken = 0;
    int          mismatch_count = 0;
    logic        send_idle = 1'b0;
    logic        recv_stall = 1'b0;
    int          idle_pct = 62;

    logic [7:0]  line_chars[64];
    int          line_len = 0;
    logic [5:0]  wrap_width = lew_pkg::WIDTH_RESET;

    line_editor_word_wrap u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic logic blank_char(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic word_char(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A)
            || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic void add_display(input logic [1:0] act, input logic [7:0] ch,
                                        input int cnt);
        display_t d;
        d.action      = act;
        d.echo_byte   = ch;
        d.erase_count = cnt[5:0];
        d.last        = 1'b0;
        expected_display.push_back(d);
    endfunction

    function automatic void predict_display(input logic [7:0] key);
        int       start_size;
        int       p;
        int       w;
        int       lim;
        display_t tail;
        start_size = expected_display.size();
        if (key == lew_pkg::KEY_DEL)
        begin
            add_display(lew_pkg::ACT_ERASE, 8'h00, 1);
            if (line_len > 0)
                line_len = line_len - 1;
        end
        else if (key == lew_pkg::KEY_KILL)
        begin
            if (line_len > 0)
                add_display(lew_pkg::ACT_ERASE, 8'h00, line_len);
            line_len = 0;
        end
        else if (key == lew_pkg::KEY_EOF)
        begin
            if (line_len == 0)
                add_display(lew_pkg::ACT_END, 8'h00, 0);
        end
        else if (key == lew_pkg::KEY_WERASE)
        begin
            p = line_len;
            while (p > 0 && blank_char(line_chars[6'(p - 1)]))
                p = p - 1;
            while (p > 0 && word_char(line_chars[6'(p - 1)]))
                p = p - 1;
            if (line_len > p)
                add_display(lew_pkg::ACT_ERASE, 8'h00, line_len - p);
            line_len = p;
        end
        else if (word_char(key) || blank_char(key))
        begin
            lim = int'(wrap_width);
            if (lim < 2)
                lim = 2;
            if (lim > 62)
                lim = 62;
            if (line_len >= lim)
            begin
                w = 0;
                while (w < line_len && word_char(line_chars[6'(line_len - 1 - w)]))
                    w = w + 1;
                if (w == line_len)
                    w = 0;
                if (w > 0)
                    add_display(lew_pkg::ACT_ERASE, 8'h00, w);
                add_display(lew_pkg::ACT_ECHO, lew_pkg::KEY_LF, 0);
                for (int j = 0; j < w; j++)
                begin
                    line_chars[6'(j)] = line_chars[6'(line_len - w + j)];
                    add_display(lew_pkg::ACT_ECHO, line_chars[6'(j)], 0);
                end
                line_len = w;
            end
            add_display(lew_pkg::ACT_ECHO, key, 0);
            line_chars[6'(line_len)] = key;
            line_len = (key == lew_pkg::KEY_LF) ? 0 : ((line_len + 1) % 64);
        end
        else
        begin
            add_display(lew_pkg::ACT_BELL, lew_pkg::BELL_BYTE, 0);
        end
        if (expected_display.size() > start_size)
        begin
            tail = expected_display.pop_back();
            tail.last = 1'b1;
            expected_display.push_back(tail);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predict_display(s_tdata);
                keys_taken <= keys_taken + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (keys_to_type.size() > 0
                    && !(send_idle && $urandom_range(0, 99) < idle_pct))
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= keys_to_type.pop_front();
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        display_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_display.size() == 0)
                begin
                    $error("unexpected transfer: action %0d, echo_byte 0x%02h, erase_count %0d",
                           m_tuser, m_tdata[7:0], m_tdata[13:8]);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_display.pop_front();
                    if (m_tuser !== want.action)
                    begin
                        $error("action: expected %0d, got %0d", want.action, m_tuser);
                        mismatch_count++;
                    end
                    if (m_tdata[7:0] !== want.echo_byte)
                    begin
                        $error("echo_byte: expected 0x%02h, got 0x%02h",
                               want.echo_byte, m_tdata[7:0]);
                        mismatch_count++;
                    end
                    if (m_tdata[13:8] !== want.erase_count)
                    begin
                        $error("erase_count: expected %0d, got %0d",
                               want.erase_count, m_tdata[13:8]);
                        mismatch_count++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, m_tlast);
                        mismatch_count++;
                    end
                end
            end
            m_tready <= !(recv_stall && $urandom_range(0, 99) < idle_pct);
        end
    end

    task automatic type_key(input logic [7:0] key);
        keys_to_type.push_back(key);
        keys_typed++;
    endtask

    task automatic wait_until_idle();
        do
            @(posedge clk);
        while (keys_taken != keys_typed || expected_display.size() != 0);
        repeat (320) @(posedge clk);
    endtask

    task automatic write_width(input logic [5:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        wrap_width = value;
    endtask

    function automatic logic [7:0] random_word_char();
        int k;
        k = $urandom_range(0, 61);
        if (k < 10)
            return 8'(8'h30 + k);
        else if (k < 36)
            return 8'(8'h41 + k - 10);
        else
            return 8'(8'h61 + k - 36);
    endfunction

    task automatic type_random_keys(input int count);
        int start;
        int r;
        int n;
        start = keys_typed;
        while (keys_typed - start < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 8);
                repeat (n) type_key(random_word_char());
            end
            else if (r < 65)
            begin
                if ($urandom_range(0, 3) == 0)
                    type_key(8'(8'h09 + $urandom_range(0, 4)));
                else
                    type_key(8'h20);
            end
            else if (r < 75)
            begin
                type_key(lew_pkg::KEY_DEL);
            end
            else if (r < 80)
            begin
                type_key(lew_pkg::KEY_WERASE);
            end
            else if (r < 83)
            begin
                type_key(lew_pkg::KEY_KILL);
            end
            else if (r < 86)
            begin
                type_key(lew_pkg::KEY_EOF);
            end
            else
            begin
                type_key(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial
    begin
        logic [5:0] widths[7];
        widths = '{6'd62, 6'd2, 6'd63, 6'd0, 6'd17, 6'd1, 6'd40};
        widths[6] = 6'($urandom_range(2, 62));
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        write_width(6'd4);
        type_key(lew_pkg::KEY_EOF);
        type_key(lew_pkg::KEY_DEL);
        type_key(lew_pkg::KEY_KILL);
        type_key(lew_pkg::KEY_WERASE);
        type_key(8'h00);
        type_key(8'hFF);
        type_key(8'h61);
        type_key(8'h62);
        type_key(8'h20);
        type_key(8'h63);
        type_key(8'h64);
        type_key(lew_pkg::KEY_EOF);
        type_key(8'h5A);
        type_key(8'h39);
        type_key(8'h30);
        type_key(8'h09);
        type_key(8'h0D);
        type_key(lew_pkg::KEY_WERASE);
        type_key(8'h41);
        type_key(8'h7A);
        type_key(lew_pkg::KEY_KILL);
        type_key(8'h78);
        type_key(lew_pkg::KEY_LF);
        type_key(8'h71);
        type_key(lew_pkg::KEY_DEL);
        wait_until_idle();
        for (int phase = 1; phase <= 7; phase++)
        begin
            write_width(widths[phase-1]);
            send_idle  = (phase % 4 == 1) || (phase % 4 == 3);
            recv_stall = (phase % 4 == 2) || (phase % 4 == 3);
            idle_pct   = (send_idle && recv_stall) ? 38 : 62;
            type_random_keys(50);
            wait_until_idle();
        end
        if (mismatch_count == 0 && expected_display.size() == 0)
            $display("line_editor_word_wrap regression: pass");
        else
            $display("line_editor_word_wrap regression: fail");
        $finish;
    end

    initial
    begin
        #15_000_000;
        $display("line_editor_word_wrap regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
src/lew_pkg.sv
src/lew_ctrl.sv
src/lew_datapath.sv
src/line_editor_word_wrap.sv
tb/sv/testbench.sv
